// File: design/obms_pkg.sv
// ----------------------------------------------------------------------------
// obms_pkg
// Shared types, codes and helpers of the opaque bounding margin scan.
// ----------------------------------------------------------------------------
package obms_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int COL_W   = 10;
	localparam int BASE_W  = COL_W + 3;
	localparam int LANES   = 8;
	localparam int LANE_W  = $clog2(LANES);

	typedef enum logic [2:0] {
		FMT_A8     = 3'd0,
		FMT_P4     = 3'd1,
		FMT_P2     = 3'd2,
		FMT_P1     = 3'd3,
		FMT_OPAQUE = 3'd4
	} fmt_t;

	typedef enum logic [2:0] {
		REG_PIXEL_FORMAT  = 3'd0,
		REG_PALETTE_ALPHA = 3'd1,
		REG_ORIGIN_COL    = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4
	} reg_idx_t;

	// Settings shared by all lanes for the byte in flight.
	typedef struct packed {
		logic [2:0]        fmt;
		logic [31:0]       palette;
		logic [BASE_W-1:0] base;
		logic [COL_W-1:0]  lo;
		logic [COL_W-1:0]  hi;
		logic [1:0]        shift;
		logic              active;
	} lane_ctl_t;

	typedef struct packed {
		logic             any;
		logic [COL_W-1:0] lx_min;
		logic [COL_W-1:0] lx_max;
	} merge_t;

	// log2 of the number of pixels held by one byte.
	function automatic logic [1:0] fmt_shift(input logic [2:0] fmt);
		logic [1:0] s;
		case (fmt)
			FMT_A8:  s = 2'd0;
			FMT_P4:  s = 2'd1;
			FMT_P2:  s = 2'd2;
			default: s = 2'd3;
		endcase
		return s;
	endfunction

endpackage

// File: design/obms_lane.sv
// ----------------------------------------------------------------------------
// obms_lane
// One pixel lane: decodes the alpha of pixel k of the byte and tests it
// against the clipped row window.
// ----------------------------------------------------------------------------
module obms_lane
	import obms_pkg::*;
(
	input  logic [LANE_W-1:0] lane_idx,
	input  logic [7:0]        pixel_byte,
	input  lane_ctl_t         ctl,
	output logic              hit
);

	logic [BASE_W-1:0] col;
	logic [3:0]        entry;
	logic [1:0]        alpha;
	logic              lane_ok;
	logic              in_window;

	assign col       = ctl.base + BASE_W'(lane_idx);
	assign lane_ok   = (4'(lane_idx) < (4'd1 << ctl.shift));
	assign in_window = (col >= BASE_W'(ctl.lo)) && (col <= BASE_W'(ctl.hi));

	always_comb begin
		entry = 4'd0;
		case (ctl.fmt)
			FMT_A8: begin
				alpha = pixel_byte[7:6];
			end
			FMT_P4: begin
				entry = lane_idx[0] ? pixel_byte[3:0] : pixel_byte[7:4];
				alpha = ctl.palette[{entry, 1'b0} +: 2];
			end
			FMT_P2: begin
				entry = {2'b00, pixel_byte[{~lane_idx[1:0], 1'b0} +: 2]};
				alpha = ctl.palette[{entry, 1'b0} +: 2];
			end
			FMT_P1: begin
				entry = {3'b000, pixel_byte[~lane_idx]};
				alpha = ctl.palette[{entry, 1'b0} +: 2];
			end
			default: begin
				alpha = 2'd3;
			end
		endcase
	end

	assign hit = ctl.active && lane_ok && in_window && (alpha != 2'd0);

endmodule

// File: design/obms_merge.sv
// ----------------------------------------------------------------------------
// obms_merge
// Combines the lane hits of one byte into its leftmost and rightmost opaque
// column relative to the bounds.
// ----------------------------------------------------------------------------
module obms_merge
	import obms_pkg::*;
(
	input  logic [LANES-1:0]  hits,
	input  logic [BASE_W-1:0] base,
	input  logic [COL_W-1:0]  origin,
	output merge_t            result
);

	logic [LANE_W-1:0] k_min;
	logic [LANE_W-1:0] k_max;
	logic [BASE_W-1:0] col_min;
	logic [BASE_W-1:0] col_max;

	// Lane columns rise with the lane number, so the first and last hits
	// are the extremes.
	always_comb begin
		k_min = '0;
		k_max = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (hits[i]) k_min = LANE_W'(i);
		end
		for (int i = 0; i < LANES; i++) begin
			if (hits[i]) k_max = LANE_W'(i);
		end
	end

	assign col_min = base + BASE_W'(k_min) - BASE_W'(origin);
	assign col_max = base + BASE_W'(k_max) - BASE_W'(origin);

	assign result.any    = |hits;
	assign result.lx_min = col_min[COL_W-1:0];
	assign result.lx_max = col_max[COL_W-1:0];

endmodule

// File: design/opaque_bounding_margin_scan.sv
// ----------------------------------------------------------------------------
// opaque_bounding_margin_scan
// Finds the bounding box of the opaque pixels of a streamed bitmap and
// reports the transparent margins around it.
// ----------------------------------------------------------------------------
// The block takes one bitmap byte per cycle, back to back, as long as results
// are taken. Eight pixel lanes decode a byte in parallel into stage 1; the merge
// fills stage 2, whose bytes update the extrema registers, and m_axis_tvalid rises
// once the byte marked with tlast leaves stage 2 for the output register. While a
// result waits for m_axis_tready, bytes still enter until the next byte marked
// with tlast sits in stage 2 and stage 1 behind it is full.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so while the stream is idle, as the block itself does not enforce it.
module opaque_bounding_margin_scan
	import obms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pixel_byte, byte_index, row_index, window_first, window_final
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// margin_north, margin_east, margin_south, margin_west, zero fill
	output logic [47:0] m_axis_tdata,
	// all_clear
	output logic        m_axis_tuser
);

	logic [2:0]       fmt_q;
	logic [31:0]      palette_q;
	logic [COL_W-1:0] origin_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_A8;
			palette_q <= '0;
			origin_q  <= '0;
			width_q   <= '0;
			height_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT:  fmt_q     <= cfg_data[2:0];
				REG_PALETTE_ALPHA: palette_q <= cfg_data;
				REG_ORIGIN_COL:    origin_q  <= cfg_data[COL_W-1:0];
				REG_IMAGE_WIDTH:   width_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  height_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	assign w_eff = (width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
	assign h_eff = (height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;

	// Input fields.
	logic [7:0]       in_byte;
	logic [COL_W-1:0] in_bidx;
	logic [COL_W-1:0] in_row;
	logic [COL_W-1:0] in_wfirst;
	logic [COL_W-1:0] in_wfinal;

	assign in_byte   = s_axis_tdata[7:0];
	assign in_bidx   = s_axis_tdata[17:8];
	assign in_row    = s_axis_tdata[27:18];
	assign in_wfirst = s_axis_tdata[37:28];
	assign in_wfinal = s_axis_tdata[47:38];

	// Window clipped to the image bounds.
	lane_ctl_t        ctl;
	logic [COL_W+1:0] right;

	assign right = (COL_W+2)'(origin_q) + (COL_W+2)'(w_eff) - (COL_W+2)'(1);

	always_comb begin
		ctl.fmt     = fmt_q;
		ctl.palette = palette_q;
		ctl.shift   = fmt_shift(fmt_q);
		ctl.base    = BASE_W'(in_bidx) << ctl.shift;
		ctl.lo      = (in_wfirst > origin_q) ? in_wfirst : origin_q;
		ctl.hi      = ((COL_W+2)'(in_wfinal) < right) ? in_wfinal : right[COL_W-1:0];
		ctl.active  = (w_eff != '0) && (DIM_W'(in_row) < h_eff);
	end

	logic [LANES-1:0] hits;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		obms_lane u_lane (
			.lane_idx   (LANE_W'(k)),
			.pixel_byte (in_byte),
			.ctl        (ctl),
			.hit        (hits[k])
		);
	end

	// Pipeline control.
	logic in_fire;
	logic load_s1;
	logic load_s2;
	logic adv_s2;
	logic valid_s1;
	logic valid_s2;
	logic last_s2;
	logic out_valid_q;

	assign adv_s2        = valid_s2 && (!last_s2 || !out_valid_q || m_axis_tready);
	assign load_s2       = !valid_s2 || adv_s2;
	assign load_s1       = !valid_s1 || load_s2;
	assign s_axis_tready = load_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Stage 1: lane hits.
	logic [LANES-1:0]  hits_s1;
	logic [BASE_W-1:0] base_s1;
	logic [COL_W-1:0]  row_s1;
	logic              last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hits_s1 <= hits;
			base_s1 <= ctl.base;
			row_s1  <= in_row;
			last_s1 <= s_axis_tlast;
		end
	end

	// Stage 2: merged extremes of the byte.
	merge_t           merged;
	merge_t           merged_s2;
	logic [COL_W-1:0] row_s2;

	obms_merge u_merge (
		.hits   (hits_s1),
		.base   (base_s1),
		.origin (origin_q),
		.result (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			merged_s2 <= merged;
			row_s2    <= row_s1;
			last_s2   <= last_s1;
		end
	end

	// Running extrema of the image.
	logic [DIM_W-1:0] least_col_q;
	logic [DIM_W-1:0] greatest_col_q;
	logic [DIM_W-1:0] least_row_q;
	logic [DIM_W-1:0] greatest_row_q;
	logic             seen_q;

	logic [DIM_W-1:0] lc_new;
	logic [DIM_W-1:0] gc_new;
	logic [DIM_W-1:0] lr_new;
	logic [DIM_W-1:0] gr_new;
	logic             seen_new;

	always_comb begin
		lc_new   = least_col_q;
		gc_new   = greatest_col_q;
		lr_new   = least_row_q;
		gr_new   = greatest_row_q;
		seen_new = seen_q || merged_s2.any;
		if (merged_s2.any) begin
			if (DIM_W'(merged_s2.lx_min) < least_col_q) lc_new = DIM_W'(merged_s2.lx_min);
			if (DIM_W'(merged_s2.lx_max) > greatest_col_q) gc_new = DIM_W'(merged_s2.lx_max);
			if (DIM_W'(row_s2) < least_row_q) lr_new = DIM_W'(row_s2);
			if (DIM_W'(row_s2) > greatest_row_q) gr_new = DIM_W'(row_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_col_q    <= DIM_W'(MAX_DIM);
			greatest_col_q <= '0;
			least_row_q    <= DIM_W'(MAX_DIM);
			greatest_row_q <= '0;
			seen_q         <= 1'b0;
		end else if (adv_s2) begin
			if (last_s2) begin
				least_col_q    <= DIM_W'(MAX_DIM);
				greatest_col_q <= '0;
				least_row_q    <= DIM_W'(MAX_DIM);
				greatest_row_q <= '0;
				seen_q         <= 1'b0;
			end else begin
				least_col_q    <= lc_new;
				greatest_col_q <= gc_new;
				least_row_q    <= lr_new;
				greatest_row_q <= gr_new;
				seen_q         <= seen_new;
			end
		end
	end

	// A margin that would be negative after a mid-image bounds change is zero.
	function automatic logic [DIM_W-1:0] margin_of(input logic [DIM_W-1:0] size,
	                                               input logic [DIM_W-1:0] extreme);
		logic [DIM_W:0] ext1;
		ext1 = (DIM_W+1)'(extreme) + (DIM_W+1)'(1);
		return (ext1 > (DIM_W+1)'(size)) ? '0 : DIM_W'(size - extreme - DIM_W'(1));
	endfunction

	// Output register.
	logic [DIM_W-1:0] north_q;
	logic [DIM_W-1:0] east_q;
	logic [DIM_W-1:0] south_q;
	logic [DIM_W-1:0] west_q;
	logic             clear_q;
	logic             out_load;

	assign out_load = adv_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (seen_new) begin
				north_q <= lr_new;
				east_q  <= margin_of(w_eff, gc_new);
				south_q <= margin_of(h_eff, gr_new);
				west_q  <= lc_new;
				clear_q <= 1'b0;
			end else begin
				north_q <= '0;
				east_q  <= '0;
				south_q <= '0;
				west_q  <= '0;
				clear_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, west_q, south_q, east_q, north_q};
	assign m_axis_tuser  = clear_q;

endmodule

// File: test/margin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// margin_checker
// Watches the configuration port and both streams of the opaque bounding
// margin scan, predicts the margins of every image and compares each accepted
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module margin_checker
	import obms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// pixel_byte, byte_index, row_index, window_first, window_final
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// margin_north, margin_east, margin_south, margin_west, zero fill
	input  logic [47:0] m_axis_tdata,
	// all_clear
	input  logic        m_axis_tuser,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [10:0] north;
		logic [10:0] east;
		logic [10:0] south;
		logic [10:0] west;
		logic        clear;
	} margins_t;

	margins_t margin_q[$];

	// Shadow copy of the configuration registers.
	int fmt_code;
	int palette_bits;
	int origin;
	int width;
	int height;

	// Running extents of the opaque pixels of the current image.
	int  least_col;
	int  greatest_col;
	int  least_row;
	int  greatest_row;
	bit  seen_opaque;

	function automatic int margin_gap(input int size, input int extreme);
		return (extreme + 1 > size) ? 0 : size - 1 - extreme;
	endfunction

	task automatic clear_extents();
		least_col    = MAX_DIM;
		greatest_col = 0;
		least_row    = MAX_DIM;
		greatest_row = 0;
		seen_opaque  = 1'b0;
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic scan_byte(input logic [47:0] data, input logic last);
		int pix;
		int bidx;
		int row;
		int wfirst;
		int wfinal;
		int w;
		int h;
		int bits;
		int per;
		int lo;
		int hi;
		int col;
		int entry;
		int alpha;
		margins_t m;
		pix    = data[7:0];
		bidx   = data[17:8];
		row    = data[27:18];
		wfirst = data[37:28];
		wfinal = data[47:38];
		w = (width > MAX_DIM) ? MAX_DIM : width;
		h = (height > MAX_DIM) ? MAX_DIM : height;
		case (fmt_code)
			FMT_A8:  bits = 8;
			FMT_P4:  bits = 4;
			FMT_P2:  bits = 2;
			default: bits = 1;
		endcase
		if (w > 0 && row < h) begin
			per = 8 / bits;
			lo = (wfirst > origin) ? wfirst : origin;
			hi = (wfinal < origin + w - 1) ? wfinal : origin + w - 1;
			for (int k = 0; k < per; k++) begin
				col = bidx * per + k;
				if (col >= lo && col <= hi) begin
					if (fmt_code == FMT_A8) begin
						alpha = (pix >> 6) & 3;
					end else if (fmt_code == FMT_P4 || fmt_code == FMT_P2 ||
							fmt_code == FMT_P1) begin
						// Pixels sit MSB first, the leftmost in the high bits.
						entry = (pix >> (8 - bits * (k + 1))) & ((1 << bits) - 1);
						alpha = (palette_bits >> (2 * entry)) & 3;
					end else begin
						alpha = 3;
					end
					if (alpha != 0) begin
						if (col - origin < least_col) least_col = col - origin;
						if (col - origin > greatest_col) greatest_col = col - origin;
						if (row < least_row) least_row = row;
						if (row > greatest_row) greatest_row = row;
						seen_opaque = 1'b1;
					end
				end
			end
		end
		if (last) begin
			if (seen_opaque) begin
				m.north = least_row;
				m.east  = margin_gap(w, greatest_col);
				m.south = margin_gap(h, greatest_row);
				m.west  = least_col;
				m.clear = 1'b0;
			end else begin
				m = '0;
				m.clear = 1'b1;
			end
			margin_q.push_back(m);
			clear_extents();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		margins_t want;
		if (!arst_n) begin
			fmt_code     = FMT_A8;
			palette_bits = 0;
			origin       = 0;
			width        = 0;
			height       = 0;
			errors       = 0;
			clear_extents();
			margin_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PIXEL_FORMAT:  fmt_code = cfg_data[2:0];
					REG_PALETTE_ALPHA: palette_bits = cfg_data;
					REG_ORIGIN_COL:    origin = cfg_data[9:0];
					REG_IMAGE_WIDTH:   width = cfg_data[10:0];
					REG_IMAGE_HEIGHT:  height = cfg_data[10:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				scan_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (margin_q.size() == 0) begin
					$error("margin result with no image pending");
					errors++;
				end else begin
					want = margin_q.pop_front();
					compare_field("margin_north", want.north, m_axis_tdata[10:0]);
					compare_field("margin_east", want.east, m_axis_tdata[21:11]);
					compare_field("margin_south", want.south, m_axis_tdata[32:22]);
					compare_field("margin_west", want.west, m_axis_tdata[43:33]);
					compare_field("all_clear", want.clear, m_axis_tuser);
				end
			end
			outstanding <= margin_q.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bitmap bytes and configuration into the opaque bounding margin scan
// with random gaps and stalls; a checker beside the block predicts and
// compares every margin result.
// ----------------------------------------------------------------------------
module testbench
	import obms_pkg::*;
();

	localparam int          ITEMS       = 1100;
	localparam int          DRAIN       = 8;
	localparam int          HOLD_CYCLES = 300;
	localparam int          LIMIT       = 600000;
	localparam logic [2:0]  FMT_UNUSED  = 3'd7;
	localparam logic [2:0]  REG_UNUSED  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	int errors;
	int outstanding;
	int sent;
	int cycles;
	bit quiet;
	bit hold_req;

	// What the stimulus last wrote, used only to shape the bytes.
	logic [2:0] cur_fmt;
	int         cur_origin;
	int         cur_width;
	int         cur_height;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	opaque_bounding_margin_scan uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	margin_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.errors(errors),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	task automatic send_byte(input logic [7:0] pix, input int bidx, row, wf, wl,
			input bit last);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {wl[9:0], wf[9:0], row[9:0], bidx[9:0], pix};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Waits until every result has arrived and the pipeline has drained.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_PIXEL_FORMAT: cur_fmt = val[2:0];
			REG_ORIGIN_COL:   cur_origin = val[9:0];
			REG_IMAGE_WIDTH:  cur_width = val[10:0];
			REG_IMAGE_HEIGHT: cur_height = val[10:0];
			default: ;
		endcase
	endtask

	// Bytes mostly land inside the bounds and the window, with some noise.
	task automatic send_image(input bit with_end, input int max_bytes);
		int nbytes;
		int per;
		int w_eff;
		int h_eff;
		int c0;
		int c1;
		int row;
		int bidx;
		int wf;
		int wl;
		int tmp;
		logic [7:0] pix;
		per = (cur_fmt == FMT_A8) ? 1 : (cur_fmt == FMT_P4) ? 2 : (cur_fmt == FMT_P2) ? 4 : 8;
		w_eff = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
		h_eff = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
		c0 = cur_origin;
		c1 = c0 + ((w_eff > 0) ? w_eff - 1 : 0);
		if (c1 > 1023) c1 = 1023;
		nbytes = $urandom_range(1, max_bytes);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				pix  = $urandom;
				bidx = $urandom_range(0, 1023);
				row  = $urandom_range(0, 1023);
				wf   = $urandom_range(0, 1023);
				wl   = $urandom_range(0, 1023);
			end else begin
				if (h_eff > 0 && $urandom_range(0, 9) != 0)
					row = $urandom_range(0, h_eff - 1);
				else
					row = $urandom_range(h_eff, h_eff + 2);
				if (row > 1023) row = 1023;
				bidx = $urandom_range(c0 / per, c1 / per);
				wf = $urandom_range((c0 > 3) ? c0 - 3 : 0, (c0 + c1) / 2);
				wl = $urandom_range(wf, (c1 + 3 > 1023) ? 1023 : c1 + 3);
				if ($urandom_range(0, 19) == 0) begin
					tmp = wf;
					wf  = wl;
					wl  = tmp;
				end
				case ($urandom_range(0, 9))
					0, 1, 2: pix = 8'h00;
					3:       pix = 8'hFF;
					default: pix = $urandom;
				endcase
			end
			send_byte(pix, bidx, row, wf, wl, with_end && i == nbytes - 1);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = quiet ? 0 : pick_gap();
				if (gap == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		int phase;
		int r;
		int n;
		logic [31:0] val;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_PIXEL_FORMAT;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		sent          = 0;
		cycles        = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		cur_fmt       = FMT_A8;
		cur_origin    = 0;
		cur_width     = 0;
		cur_height    = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration has zero width, so nothing is opaque.
		send_byte(8'hFF, 0, 0, 0, 1023, 1'b1);
		settle();

		write_reg(REG_PIXEL_FORMAT, FMT_A8);
		write_reg(REG_PALETTE_ALPHA, 32'h0);
		write_reg(REG_ORIGIN_COL, 0);
		write_reg(REG_IMAGE_WIDTH, 16);
		write_reg(REG_IMAGE_HEIGHT, 8);
		send_byte(8'h3F, 3, 2, 0, 1023, 1'b0);
		send_byte(8'h40, 5, 3, 0, 1023, 1'b0);
		send_byte(8'hC0, 9, 6, 0, 1023, 1'b1);
		settle();

		// Row below the bounds, an empty window and a clipped column.
		send_byte(8'hFF, 0, 8, 0, 1023, 1'b0);
		send_byte(8'hFF, 1, 1, 5, 2, 1'b0);
		send_byte(8'hFF, 2, 1, 3, 1023, 1'b0);
		send_byte(8'hFF, 15, 0, 0, 1023, 1'b1);
		settle();

		// Oversized bounds at the far right origin.
		write_reg(REG_PIXEL_FORMAT, FMT_P4);
		write_reg(REG_PALETTE_ALPHA, 32'hC000_0004);
		write_reg(REG_ORIGIN_COL, 1023);
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 1500);
		send_byte(8'h01, 511, 0, 0, 1023, 1'b0);
		send_byte(8'hF0, 1023, 1023, 1023, 1023, 1'b1);
		settle();

		write_reg(REG_PIXEL_FORMAT, FMT_P2);
		write_reg(REG_PALETTE_ALPHA, 32'h0000_00E4);
		write_reg(REG_ORIGIN_COL, 4);
		write_reg(REG_IMAGE_WIDTH, 12);
		write_reg(REG_IMAGE_HEIGHT, 2);
		send_byte(8'h1B, 1, 1, 0, 1023, 1'b1);
		settle();

		write_reg(REG_PIXEL_FORMAT, FMT_P1);
		write_reg(REG_PALETTE_ALPHA, 32'h0000_000C);
		write_reg(REG_ORIGIN_COL, 0);
		write_reg(REG_IMAGE_WIDTH, 1024);
		write_reg(REG_IMAGE_HEIGHT, 1024);
		send_byte(8'h81, 127, 1023, 0, 1023, 1'b0);
		send_byte(8'h00, 0, 0, 0, 1023, 1'b1);
		settle();

		// Opaque formats ignore the byte value.
		write_reg(REG_PIXEL_FORMAT, FMT_OPAQUE);
		send_byte(8'h00, 2, 5, 17, 20, 1'b1);
		settle();
		write_reg(REG_PIXEL_FORMAT, FMT_UNUSED);
		send_byte(8'h00, 0, 0, 0, 0, 1'b1);
		settle();

		write_reg(REG_IMAGE_WIDTH, 0);
		send_byte(8'hFF, 0, 0, 0, 1023, 1'b1);
		settle();
		write_reg(REG_IMAGE_WIDTH, 8);
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_byte(8'hFF, 0, 0, 0, 1023, 1'b1);
		settle();

		// The bounds shrink under an open image, so the far margins clamp to zero.
		write_reg(REG_PIXEL_FORMAT, FMT_A8);
		write_reg(REG_IMAGE_WIDTH, 64);
		write_reg(REG_IMAGE_HEIGHT, 32);
		send_byte(8'hFF, 40, 20, 0, 1023, 1'b0);
		settle();
		write_reg(REG_IMAGE_WIDTH, 8);
		write_reg(REG_IMAGE_HEIGHT, 4);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_byte(8'h00, 0, 0, 0, 1023, 1'b1);

		phase = 0;
		while (sent < ITEMS) begin
			settle();
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			val = (r < 9) ? $urandom_range(int'(FMT_A8), int'(FMT_OPAQUE))
				: $urandom_range(int'(FMT_OPAQUE) + 1, int'(FMT_UNUSED));
			write_reg(REG_PIXEL_FORMAT, val);
			case ($urandom_range(0, 9))
				0:       val = 32'h0;
				1:       val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			write_reg(REG_PALETTE_ALPHA, val);
			case ($urandom_range(0, 9))
				0:       val = 0;
				1:       val = 1023;
				2, 3:    val = $urandom_range(0, 1023);
				default: val = $urandom_range(0, 64);
			endcase
			write_reg(REG_ORIGIN_COL, val);
			case ($urandom_range(0, 19))
				0:       val = 0;
				1:       val = 1;
				2:       val = 1024;
				3:       val = $urandom_range(1025, 2047);
				default: val = $urandom_range(2, 48);
			endcase
			write_reg(REG_IMAGE_WIDTH, val);
			case ($urandom_range(0, 19))
				0:       val = 0;
				1:       val = 1;
				2:       val = 1024;
				3:       val = 2047;
				default: val = $urandom_range(1, 8);
			endcase
			write_reg(REG_IMAGE_HEIGHT, val);
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, $urandom);

			// Hold the receiver off while short images keep coming.
			if (phase == 2 || $urandom_range(0, 9) == 0) begin
				hold_req = 1'b1;
				repeat (12) send_image(1'b1, 3);
			end
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_image(i < n - 1 || $urandom_range(0, 4) != 0, 24);
			phase++;
		end
		settle();

		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: files.f
design/obms_pkg.sv
design/obms_lane.sv
design/obms_merge.sv
design/opaque_bounding_margin_scan.sv
test/margin_checker.sv
test/testbench.sv
